// ===== rtl/psg_pkg.sv =====
// Package for the tone/noise sound generator: widths, channel record type,
// volume table and register codes. No dependencies.
package psg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int STEP_W    = 24;
    localparam int N_W       = STEP_W + 1 - FRAC_BITS;
    localparam int CNT_W     = 16;
    localparam int EDGE_W    = FRAC_BITS + 2;
    localparam int PER_W     = 11;
    localparam int ATT_W     = 4;
    localparam int VOL_W     = 12;
    localparam int LFSR_W    = 16;
    localparam int SAMPLE_W  = 16;
    localparam int DEN_W     = N_W + FRAC_BITS;
    localparam int REM_W     = DEN_W + 1;
    localparam int QUO_W     = FRAC_BITS + 1;
    localparam int PROD_W    = VOL_W + 1 + EDGE_W;
    localparam int NUM_W     = CNT_W + 4 + FRAC_BITS;
    localparam int STEPS_W   = 5;

    localparam logic [STEP_W-1:0] CLOCK_STEP_RESET = 24'd332468;
    localparam logic              CHIP_RESET       = 1'b1;
    localparam logic [PER_W-1:0]  CUTOFF           = 11'd6;
    localparam logic [PER_W-1:0]  ZERO_PER_DISC    = 11'h400;
    localparam logic [PER_W-1:0]  ZERO_PER_INTG    = 11'd1;
    localparam logic [LFSR_W-1:0] TAPS_DISC        = 16'h0006;
    localparam logic [LFSR_W-1:0] TAPS_INTG        = 16'h0009;
    localparam logic [3:0]        TOP_DISC         = 4'd14;
    localparam logic [3:0]        TOP_INTG         = 4'd15;
    localparam logic [2:0]        LATCH_NOISE      = 3'd6;
    localparam logic [2:0]        LATCH_RESET      = 3'd3;

    localparam logic REG_CLOCK_STEP = 1'b0;
    localparam logic REG_CHIP_TYPE  = 1'b1;
    localparam logic CMD_TICK       = 1'b0;
    localparam logic CMD_WRITE      = 1'b1;

    typedef struct packed {
        logic signed [CNT_W-1:0]  count;
        logic                     level;
        logic signed [EDGE_W-1:0] edge_val;
        logic                     edge_ok;
        logic [PER_W-1:0]         period;
        logic [ATT_W-1:0]         atten;
    } t_chan_rec;

    localparam t_chan_rec REC_RESET = '{
        count: '0, level: 1'b0, edge_val: '0, edge_ok: 1'b0,
        period: 11'd1, atten: 4'hf
    };

    // 2 dB steps, attenuation 15 is off
    function automatic logic [VOL_W-1:0] vol_of(input logic [ATT_W-1:0] a);
        logic [VOL_W-1:0] v;
        case (a)
            4'd0:    v = 12'd2800;
            4'd1:    v = 12'd2224;
            4'd2:    v = 12'd1766;
            4'd3:    v = 12'd1403;
            4'd4:    v = 12'd1114;
            4'd5:    v = 12'd885;
            4'd6:    v = 12'd703;
            4'd7:    v = 12'd558;
            4'd8:    v = 12'd443;
            4'd9:    v = 12'd352;
            4'd10:   v = 12'd280;
            4'd11:   v = 12'd222;
            4'd12:   v = 12'd176;
            4'd13:   v = 12'd140;
            4'd14:   v = 12'd111;
            default: v = 12'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/psg_tone_noise_generator_top.sv =====
// Tone/noise sound generator top level: channel memory, sequencer, divider. Depends on psg_pkg.
// Sequence: a write transfer reads the addressed record, then writes it back; a tick reads,
// evaluates and writes back each of the four channels in turn, running the shared restoring
// divider (one quotient bit a cycle) for each tone whose counter expires, and registers its sample.
// One item at a time; the input stalls while an item is in progress.
// Reset (synchronous): registers to power-up values, memory entries read as reset until written.
module psg_tone_noise_generator_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_cmd,
    input  logic [7:0]                           i_write_byte,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [psg_pkg::SAMPLE_W-1:0]  o_sample,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_index,
    input  logic [psg_pkg::STEP_W-1:0]           i_cfg_data
);
    import psg_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EVAL = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_WB   = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam logic [2:0] ST_WRD  = 3'd6;
    localparam logic [2:0] ST_WWB  = 3'd7;

    localparam logic [STEPS_W-1:0] LAST_STEP = STEPS_W'(QUO_W - 1);
    localparam logic [STEPS_W-1:0] MOD_STEPS = STEPS_W'(N_W);
    localparam logic [1:0]         CH_NOISE  = 2'd3;
    localparam logic [1:0]         CH_TONE2  = 2'd2;

    // control state
    logic [2:0]           r_state;
    logic [STEP_W-1:0]    r_clock_step;
    logic                 r_chip;
    logic [2:0]           r_lidx;
    logic [3:0]           r_nctl;
    logic [LFSR_W-1:0]    r_lfsr;
    logic [FRAC_BITS-1:0] r_phase;
    logic [1:0]           r_ch;
    logic [3:0]           r_mvalid;
    logic                 r_out_valid;
    logic [STEPS_W-1:0]   r_step;

    // payload / work registers
    t_chan_rec                  r_mem [4];
    t_chan_rec                  r_rd;
    logic [N_W-1:0]             r_n;
    logic [FRAC_BITS-1:0]       r_f;
    logic [7:0]                 r_byte;
    logic signed [SAMPLE_W-1:0] r_acc;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [CNT_W-1:0]    r_cnt;
    logic signed [CNT_W-1:0]    r_c2;
    logic                       r_hit;
    logic                       r_edge_ok;
    logic                       r_neg;
    logic [REM_W-1:0]           r_re;
    logic [DEN_W-1:0]           r_den;
    logic [QUO_W-1:0]           r_quo;
    logic [PER_W-1:0]           r_rm;
    logic [N_W-1:0]             r_nsh;
    logic signed [PROD_W-1:0]   r_prod;

    logic                 w_in_acc;
    logic [STEP_W:0]      w_acc;
    logic                 w_re;
    logic [1:0]           w_raddr;
    logic                 w_we;
    logic [1:0]           w_waddr;
    t_chan_rec            w_wdata;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;
    assign w_in_acc    = i_in_valid && (r_state == ST_IDLE);
    assign w_acc       = {{(STEP_W + 1 - FRAC_BITS){1'b0}}, r_phase} + {1'b0, r_clock_step};

    assign w_re    = (r_state == ST_RD) || (r_state == ST_WRD);
    assign w_raddr = (r_state == ST_WRD) ? r_lidx[2:1] : r_ch;

    // ---------------- evaluate: old record -> working values
    logic [VOL_W-1:0]          w_vol;
    logic signed [EDGE_W-1:0]  w_mul_op;
    logic signed [CNT_W:0]     w_cnt_dec;
    logic signed [CNT_W-1:0]   w_cnt_new;
    logic                      w_follow;
    logic signed [CNT_W+2:0]   w_whole;
    logic signed [NUM_W-1:0]   w_num;
    logic signed [NUM_W-1:0]   w_snum;
    logic [NUM_W-1:0]          w_mag;
    logic [DEN_W-1:0]          w_den;

    always_comb begin
        w_vol     = vol_of(r_rd.atten);
        w_mul_op  = r_rd.edge_ok ? r_rd.edge_val :
                    (r_rd.level ? EDGE_W'(1 << FRAC_BITS) : -EDGE_W'(1 << FRAC_BITS));
        w_follow  = (r_nctl[1:0] == 2'd3);
        w_cnt_dec = (CNT_W+1)'(r_rd.count) - $signed((CNT_W+1)'({1'b0, r_n}));
        w_cnt_new = (r_ch == CH_NOISE && w_follow) ? r_c2 : w_cnt_dec[CNT_W-1:0];
        w_whole   = $signed((CNT_W+3)'({1'b0, r_n})) + ((CNT_W+3)'(w_cnt_new) <<< 1);
        w_num     = (NUM_W'(w_whole) <<< FRAC_BITS) - $signed(NUM_W'({1'b0, r_f}));
        w_snum    = r_rd.level ? w_num : -w_num;
        w_mag     = (w_snum < 0) ? NUM_W'(-w_snum) : NUM_W'(w_snum);
        w_den     = {r_n, r_f};
    end

    // ---------------- divider step
    logic [REM_W-1:0] w_re_t;
    logic [PER_W:0]   w_rm_t;

    always_comb begin
        w_re_t = (r_step == '0) ? r_re : {r_re[REM_W-2:0], 1'b0};
        w_rm_t = {r_rm, r_nsh[N_W-1]};
    end

    // ---------------- write back
    logic signed [CNT_W+1:0]    w_cnt_rel;
    logic signed [EDGE_W-1:0]   w_q_s;
    logic [N_W:0]               w_nrel;
    logic [2:0]                 w_nsh;
    logic signed [PROD_W-1:0]   w_prod_adj;
    logic signed [PROD_W-1:0]   w_prod_q;
    logic signed [SAMPLE_W-1:0] w_contrib;
    logic [3:0]                 w_top;
    logic [LFSR_W-1:0]          w_taps;
    logic                       w_fb;
    logic [LFSR_W-1:0]          w_lfsr_step;
    logic                       w_is_tone_wr;
    logic [PER_W-1:0]           w_per_wr;
    t_chan_rec                  w_tick_rec;
    t_chan_rec                  w_write_rec;

    always_comb begin
        w_cnt_rel = (CNT_W+2)'(r_cnt) + (CNT_W+2)'({1'b0, r_n})
                  - (CNT_W+2)'({1'b0, r_rm}) + (CNT_W+2)'({1'b0, r_rd.period});
        w_q_s     = r_neg ? -EDGE_W'({1'b0, r_quo}) : EDGE_W'({1'b0, r_quo});
        w_nsh     = 3'd4 + {1'b0, r_nctl[1:0]};
        w_nrel    = ((N_W+1)'({1'b0, r_n}) >> w_nsh << w_nsh)
                  + ((N_W+1)'(16) << r_nctl[1:0]);
        w_prod_adj = r_prod + ((r_prod < 0) ? PROD_W'((1 << FRAC_BITS) - 1) : '0);
        w_prod_q   = w_prod_adj >>> FRAC_BITS;
        w_contrib  = (r_ch == CH_NOISE) ?
                     (r_lfsr[0] ? SAMPLE_W'({w_vol, 1'b0}) : '0) : w_prod_q[SAMPLE_W-1:0];
        w_top       = r_chip ? TOP_INTG : TOP_DISC;
        w_taps      = r_lfsr & (r_chip ? TAPS_INTG : TAPS_DISC);
        w_fb        = r_nctl[2] ? ^w_taps : r_lfsr[0];
        w_lfsr_step = (r_lfsr >> 1) | (LFSR_W'(w_fb) << w_top);

        w_tick_rec = r_rd;
        w_tick_rec.count = r_cnt;
        if (r_ch == CH_NOISE) begin
            if (r_hit) begin
                w_tick_rec.level = !r_rd.level;
                if (!w_follow) begin
                    w_tick_rec.count = r_cnt + CNT_W'(w_nrel);
                end
            end
        end else if (r_hit) begin
            w_tick_rec.count = w_cnt_rel[CNT_W-1:0];
            if (r_rd.period > CUTOFF) begin
                w_tick_rec.level    = !r_rd.level;
                w_tick_rec.edge_ok  = r_edge_ok;
                w_tick_rec.edge_val = r_edge_ok ? w_q_s : '0;
            end else begin
                w_tick_rec.level   = 1'b1;
                w_tick_rec.edge_ok = 1'b0;
            end
        end else begin
            w_tick_rec.edge_ok = 1'b0;
        end

        // register write: tone period, attenuation, or noise control
        w_is_tone_wr = !r_lidx[0] && (r_lidx != LATCH_NOISE);
        w_per_wr = r_byte[7] ? {1'b0, r_rd.period[9:4], r_byte[3:0]}
                             : {1'b0, r_byte[5:0], r_rd.period[3:0]};
        if (w_per_wr == '0) begin
            w_per_wr = r_chip ? ZERO_PER_INTG : ZERO_PER_DISC;
        end
        w_write_rec = r_rd;
        if (w_is_tone_wr) begin
            w_write_rec.period = w_per_wr;
        end else if (r_lidx[0]) begin
            w_write_rec.atten = r_byte[3:0];
        end
    end

    assign w_we    = (r_state == ST_WB) || (r_state == ST_WWB);
    assign w_waddr = (r_state == ST_WWB) ? r_lidx[2:1] : r_ch;
    assign w_wdata = (r_state == ST_WWB) ? w_write_rec : w_tick_rec;

    // ---------------- channel memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mvalid[w_raddr] ? r_mem[w_raddr] : REC_RESET;
        end
    end

    // ---------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_clock_step <= CLOCK_STEP_RESET;
            r_chip       <= CHIP_RESET;
            r_lidx       <= LATCH_RESET;
            r_nctl       <= '0;
            r_lfsr       <= LFSR_W'(1) << (CHIP_RESET ? TOP_INTG : TOP_DISC);
            r_phase      <= '0;
            r_ch         <= '0;
            r_mvalid     <= '0;
            r_out_valid  <= 1'b0;
            r_step       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CLOCK_STEP: r_clock_step <= i_cfg_data;
                    REG_CHIP_TYPE:  r_chip <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_we) begin
                r_mvalid[w_waddr] <= 1'b1;
            end
            // drop the transfer unless a new sample replaces it this cycle
            if (r_out_valid && !i_out_stall && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (i_cmd == CMD_WRITE) begin
                            if (i_write_byte[7]) begin
                                r_lidx <= i_write_byte[6:4];
                            end
                            r_state <= ST_WRD;
                        end else begin
                            r_phase <= w_acc[FRAC_BITS-1:0];
                            r_ch    <= '0;
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_RD:   r_state <= ST_EVAL;
                ST_EVAL: begin
                    r_step  <= '0;
                    r_state <= (r_ch != CH_NOISE && w_cnt_new <= 0) ? ST_DIV : ST_WB;
                end
                ST_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_state <= ST_WB;
                    end
                end
                ST_WB: begin
                    if (r_ch == CH_NOISE) begin
                        if (r_hit && !r_rd.level) begin
                            r_lfsr <= w_lfsr_step;
                        end
                        r_state <= ST_OUT;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= ST_RD;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_WRD: r_state <= ST_WWB;
                ST_WWB: begin
                    if (r_lidx == LATCH_NOISE) begin
                        r_nctl <= r_byte[3:0];
                        r_lfsr <= LFSR_W'(1) << w_top;
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ---------------- datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    r_byte <= i_write_byte;
                    r_n    <= w_acc[STEP_W:FRAC_BITS];
                    r_f    <= w_acc[FRAC_BITS-1:0];
                    r_acc  <= '0;
                end
            end
            ST_EVAL: begin
                r_prod    <= $signed({1'b0, w_vol}) * w_mul_op;
                r_cnt     <= w_cnt_new;
                r_hit     <= (w_cnt_new <= 0);
                r_edge_ok <= (w_den != '0);
                r_neg     <= (w_snum < 0);
                r_re      <= w_mag[REM_W-1:0];
                r_den     <= w_den;
                r_quo     <= '0;
                r_rm      <= '0;
                r_nsh     <= r_n;
                if (r_ch == CH_TONE2) begin
                    r_c2 <= w_cnt_new;
                end
            end
            ST_DIV: begin
                if (w_re_t >= REM_W'(r_den)) begin
                    r_re  <= w_re_t - REM_W'(r_den);
                    r_quo <= {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    r_re  <= w_re_t;
                    r_quo <= {r_quo[QUO_W-2:0], 1'b0};
                end
                if (r_step < MOD_STEPS) begin
                    r_nsh <= r_nsh << 1;
                    if (w_rm_t >= (PER_W+1)'(r_rd.period)) begin
                        r_rm <= PER_W'(w_rm_t - (PER_W+1)'(r_rd.period));
                    end else begin
                        r_rm <= w_rm_t[PER_W-1:0];
                    end
                end
            end
            ST_WB:  r_acc <= r_acc + w_contrib;
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    r_sample <= r_acc;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_no_mem_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_we)
        else $error("channel memory written while idle");

    a_mod_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rm < r_rd.period))
        else $error("period remainder out of range");

    a_edge_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_re <= REM_W'(r_den)))
        else $error("edge remainder exceeds divisor");

    a_tick_ends_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB && r_ch == CH_NOISE) |=> (r_state == ST_OUT))
        else $error("noise write-back not followed by sample output");
`endif

endmodule
